// File: src/sftt_pkg.sv
// Shared types and constants for the source failure throttle table.
package sftt_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam logic [31:0] LoopbackAddr = 32'h7F00_0001;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_FAILURE = 2'd1,
    KIND_LOG     = 2'd2,
    KIND_SUCCESS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_BLOCK     = 3'd3,
    REG_LOG_GAP   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_UPDATE,
    ST_OUTPUT
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] source_addr;
    logic [31:0] now_seconds;
  } event_t;

  typedef struct packed {
    logic verdict;
    logic table_full;
  } result_t;

  // One table entry as held in memory (the valid bit lives in flip-flops).
  typedef struct packed {
    logic [15:0] fail_tally;
    logic [31:0] window_begin;
    logic        is_blocked;
    logic [31:0] block_end;
    logic        has_logged;
    logic [31:0] last_log_time;
  } entry_t;

endpackage

// File: src/sftt_if.sv
// Valid/ready channel interfaces for events and results.
interface sftt_event_if import sftt_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sftt_result_if import sftt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/source_failure_throttle_table.sv
// Top level of the per-source failed-connection throttle table.
// Flow: an accepted event starts a search of the tags (one tag fetched per cycle, compared in
// the next); after a miss has scanned every entry, or after a hit, which ends the search sooner,
// the entry is read, updated and the result registered.
// One event at a time: no new event is taken until the result has been taken.
// Reset clears the valid bits and restores register defaults.
module source_failure_throttle_table import sftt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sftt_event_if.sink          evt_i,
  sftt_result_if.source       res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  // Configuration registers.
  logic        enable_q;
  logic [15:0] threshold_q;
  logic [16:0] window_q, block_q;
  logic [11:0] log_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      threshold_q <= 16'd20;
      window_q    <= 17'd60;
      block_q     <= 17'd300;
      log_gap_q   <= 12'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:    enable_q    <= cfg_data_i[0];
        REG_THRESHOLD: threshold_q <= cfg_data_i[15:0];
        REG_WINDOW:    window_q    <= cfg_data_i;
        REG_BLOCK:     block_q     <= cfg_data_i;
        REG_LOG_GAP:   log_gap_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Memories: the address tags and the entry data, both read through registers.
  logic [31:0] tag_mem [TableEntries];
  entry_t      ent_mem [TableEntries];
  logic [TableEntries-1:0] valid_q;

  state_e      state_q, state_d;
  event_t      evt_q;
  logic [CntW-1:0] scan_q;     // entry whose tag is being fetched
  logic [IdxW-1:0] cmp_idx_q;  // entry whose tag is in tag_rd_q
  logic        cmp_vld_q;
  logic [31:0] tag_rd_q;
  logic        hit_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t      ent_rd_q;
  result_t     res_q;

  // Lowest free slot, found from the valid bits while the search runs.
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  wire hit_now = cmp_vld_q && valid_q[cmp_idx_q] && (tag_rd_q == evt_q.source_addr);
  wire scan_done = (scan_q == CntW'(TableEntries)) && !cmp_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (evt_i.valid) state_d = ST_SEARCH;
      ST_SEARCH: if (hit_now || hit_q || scan_done) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUTPUT;
      ST_OUTPUT: if (res_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign evt_i.ready   = (state_q == ST_IDLE);
  assign res_o.valid   = (state_q == ST_OUTPUT);
  assign res_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Search: fetch one tag per cycle, compare it in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (state_q == ST_IDLE) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (state_q == ST_SEARCH) begin
      if (hit_now) hit_q <= 1'b1;
      cmp_vld_q <= (scan_q < CntW'(TableEntries)) && !hit_now;
      if (scan_q < CntW'(TableEntries)) scan_q <= scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && evt_i.valid) evt_q <= evt_i.payload;
    if (scan_q < CntW'(TableEntries)) tag_rd_q <= tag_mem[scan_q[IdxW-1:0]];
    cmp_idx_q <= scan_q[IdxW-1:0];
    if (state_q == ST_SEARCH && hit_now) hit_idx_q <= cmp_idx_q;
    if (state_q == ST_READ) ent_rd_q <= ent_mem[hit_idx_q];
  end

  // Update: modify the entry read from memory and write it back.
  logic        wr_en, alloc, full;
  logic [IdxW-1:0] wr_idx;
  entry_t      e, e_new;
  logic        verdict;
  logic [31:0] diff;
  logic [15:0] tally;

  always_comb begin
    alloc   = 1'b0;
    full    = 1'b0;
    verdict = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = hit_idx_q;
    diff    = '0;
    tally   = '0;
    e       = ent_rd_q;
    if (!hit_q) begin
      e = '{fail_tally: 16'd0, window_begin: evt_q.now_seconds, is_blocked: 1'b0,
            block_end: 32'd0, has_logged: 1'b0, last_log_time: 32'd0};
      wr_idx = free_idx;
    end
    e_new = e;
    case (kind_e'(evt_q.kind))
      KIND_CHECK: begin
        if (enable_q && evt_q.source_addr != LoopbackAddr && hit_q && e.is_blocked) begin
          diff = evt_q.now_seconds - e.block_end;
          if (!diff[31]) begin
            e_new.is_blocked = 1'b0;
            e_new.fail_tally = '0;
            wr_en = 1'b1;
          end else begin
            verdict = 1'b1;
          end
        end
      end
      KIND_FAILURE: begin
        if (enable_q) begin
          if (!hit_q && !free_found) begin
            full = 1'b1;
          end else begin
            alloc = !hit_q;
            wr_en = 1'b1;
            diff  = evt_q.now_seconds - e.window_begin;
            tally = e.fail_tally;
            if (!diff[31] && diff > {15'd0, window_q}) begin
              e_new.window_begin = evt_q.now_seconds;
              tally = '0;
            end
            if (tally != 16'hFFFF) tally = tally + 16'd1;
            e_new.fail_tally = tally;
            if (tally >= threshold_q) begin
              e_new.is_blocked = 1'b1;
              e_new.block_end  = evt_q.now_seconds + {15'd0, block_q};
            end
          end
        end
      end
      KIND_LOG: begin
        if (!hit_q && !free_found) begin
          full    = 1'b1;
          verdict = 1'b1;
        end else begin
          alloc = !hit_q;
          wr_en = 1'b1;
          diff  = evt_q.now_seconds - e.last_log_time;
          if (log_gap_q != '0 && e.has_logged && (diff[31] || diff < {20'd0, log_gap_q})) begin
            verdict = 1'b0;
          end else begin
            e_new.last_log_time = evt_q.now_seconds;
            e_new.has_logged    = 1'b1;
            verdict = 1'b1;
          end
        end
      end
      KIND_SUCCESS: begin
        if (hit_q) begin
          e_new.fail_tally = '0;
          e_new.is_blocked = 1'b0;
          wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  wire do_update = (state_q == ST_UPDATE);

  always_ff @(posedge clk_i) begin
    if (do_update && wr_en) ent_mem[wr_idx] <= e_new;
    if (do_update && alloc) tag_mem[wr_idx] <= evt_q.source_addr;
    if (do_update) res_q <= '{verdict: verdict, table_full: full};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                valid_q <= '0;
    else if (do_update && alloc) valid_q[wr_idx] <= 1'b1;
  end

  // A full-table report never coincides with an allocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_update && full) |-> !alloc) else $error("full and alloc together");
  // A check or success event never allocates an entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_update && (evt_q.kind == KIND_CHECK || evt_q.kind == KIND_SUCCESS)) |-> !alloc)
    else $error("allocation on check or success");
  // The result stays put while it waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_q)))
    else $error("result changed while stalled");
  // No new event is taken while one is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !evt_i.ready) else $error("ready while busy");

endmodule
